// ----- design/byte_to_word36_packer_defines.svh -----
// ----------------------------------------------------------------------------
// byte_to_word36_packer_defines
// assertion macros shared by the packer's checker
// ----------------------------------------------------------------------------
`ifndef BYTE_TO_WORD36_PACKER_DEFINES_SVH
`define BYTE_TO_WORD36_PACKER_DEFINES_SVH

// same-cycle implication under an active-low reset
`define B2W_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication under an active-low reset
`define B2W_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/b2w36_pkg.sv -----
// ----------------------------------------------------------------------------
// b2w36_pkg
// types, constants and packing helpers for the byte to 36-bit word packer
// ----------------------------------------------------------------------------
package b2w36_pkg;

  // format modes
  localparam logic [1:0] MODE_TEXT  = 2'd0;
  localparam logic [1:0] MODE_SEVEN = 2'd1;
  localparam logic [1:0] MODE_CORE  = 2'd2;

  // characters
  localparam logic [7:0] CHAR_LF = 8'h0A;
  localparam logic [7:0] CHAR_CR = 8'h0D;

  localparam int unsigned WORD_W = 36;
  localparam int unsigned LEN_W  = 32;

  // slot of the byte that completes a word
  localparam logic [2:0] SLOT_LAST = 3'd4;

  // result queue between the packer and the output
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W       = PTR_W + 1;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              final_w;
    logic              binary;
    logic [LEN_W-1:0]  length;
  } res_t;

  // up to two results pushed per accepted item
  typedef struct packed {
    logic [1:0] cnt;
    res_t       a;
    res_t       b;
  } push_t;

  // bits one byte adds to the word at a given slot
  function automatic logic [WORD_W-1:0] pack_slot(input logic core, input logic [2:0] pos,
                                                  input logic [7:0] b);
    logic [WORD_W-1:0] v;
    if (core) begin
      case (pos)
        3'd1:    v = {8'b0, b, 20'b0};
        3'd2:    v = {16'b0, b, 12'b0};
        3'd3:    v = {24'b0, b, 4'b0};
        3'd4:    v = {32'b0, b[3:0]};
        default: v = {b, 28'b0};
      endcase
    end else begin
      case (pos)
        3'd1:    v = {7'b0, b[6:0], 22'b0};
        3'd2:    v = {14'b0, b[6:0], 15'b0};
        3'd3:    v = {21'b0, b[6:0], 8'b0};
        3'd4:    v = {28'b0, b[6:0], b[7]};
        default: v = {b[6:0], 29'b0};
      endcase
    end
    return v;
  endfunction

  // saturating increment of the byte count
  function automatic logic [LEN_W-1:0] sat_inc(input logic [LEN_W-1:0] x);
    return (&x) ? x : LEN_W'(x + 1'b1);
  endfunction

endpackage

// ----- design/b2w36_front.sv -----
// ----------------------------------------------------------------------------
// b2w36_front
// accepts bytes, expands line feeds, packs slots and produces result items
// ----------------------------------------------------------------------------
module b2w36_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [1:0]           mode_i,
  input  logic                 accept_i,
  input  logic [7:0]           data_byte_i,
  input  logic                 last_byte_i,
  output b2w36_pkg::push_t     push_o
);

  logic [2:0]                    pos_q, pos_d;
  logic [b2w36_pkg::WORD_W-1:0]  acc_q, acc_d;
  logic                          flag_q, flag_d;
  logic [b2w36_pkg::LEN_W-1:0]   total_q, total_d;

  // two packing steps and a flush, all combinational
  always_comb begin
    logic                          core, expand, done1, done2, flush;
    logic [7:0]                    b1;
    logic [2:0]                    pos1, pos2;
    logic [b2w36_pkg::WORD_W-1:0]  acc1, accs1, acc2;
    logic                          flag1, flag2;
    logic [b2w36_pkg::LEN_W-1:0]   tot1, tot2;
    b2w36_pkg::res_t               e1, e2, ef;

    core   = mode_i[1];
    expand = (mode_i == b2w36_pkg::MODE_TEXT) && (data_byte_i == b2w36_pkg::CHAR_LF);

    // first byte: the carriage return of an expanded line feed, else the byte
    b1    = expand ? b2w36_pkg::CHAR_CR : data_byte_i;
    acc1  = acc_q | b2w36_pkg::pack_slot(core, pos_q, b1);
    flag1 = flag_q | ((pos_q == b2w36_pkg::SLOT_LAST) && b1[7]);
    tot1  = b2w36_pkg::sat_inc(total_q);
    done1 = (pos_q == b2w36_pkg::SLOT_LAST);
    pos1  = done1 ? 3'd0 : 3'(pos_q + 3'd1);
    accs1 = done1 ? '0 : acc1;
    e1    = '{word: acc1, final_w: 1'b0, binary: flag1, length: tot1};

    // second byte: the line feed of an expansion
    if (expand) begin
      acc2  = accs1 | b2w36_pkg::pack_slot(core, pos1, b2w36_pkg::CHAR_LF);
      flag2 = flag1 | ((pos1 == b2w36_pkg::SLOT_LAST) && b2w36_pkg::CHAR_LF[7]);
      tot2  = b2w36_pkg::sat_inc(tot1);
      done2 = (pos1 == b2w36_pkg::SLOT_LAST);
    end else begin
      acc2  = accs1;
      flag2 = flag1;
      tot2  = tot1;
      done2 = 1'b0;
    end
    e2   = '{word: acc2, final_w: 1'b0, binary: flag2, length: tot2};
    pos2 = done2 ? 3'd0 : (expand ? 3'(pos1 + 3'd1) : pos1);
    if (done2) begin
      acc2 = '0;
    end

    // partial word flush on the last byte
    flush = last_byte_i && (pos2 != 3'd0);
    ef    = '{word: acc2, final_w: 1'b0, binary: flag2, length: tot2};

    pos_d   = flush ? 3'd0 : pos2;
    acc_d   = flush ? '0 : acc2;
    flag_d  = flag2;
    total_d = tot2;

    // order the results into the push slots
    push_o.a = done1 ? e1 : (done2 ? e2 : ef);
    push_o.b = ef;
    if ((done1 || done2) && flush) begin
      push_o.cnt       = 2'd2;
      push_o.b.final_w = last_byte_i;
    end else begin
      push_o.cnt       = (done1 || done2 || flush) ? 2'd1 : 2'd0;
      push_o.a.final_w = last_byte_i;
    end
    if (!accept_i) begin
      push_o.cnt = 2'd0;
    end
  end

  // packing state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      acc_q   <= '0;
      flag_q  <= 1'b0;
      total_q <= '0;
    end else if (accept_i) begin
      pos_q   <= pos_d;
      acc_q   <= acc_d;
      flag_q  <= flag_d;
      total_q <= total_d;
    end
  end

endmodule

// ----- design/b2w36_queue.sv -----
// ----------------------------------------------------------------------------
// b2w36_queue
// small result queue, two pushes and one pop per cycle
// ----------------------------------------------------------------------------
module b2w36_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  b2w36_pkg::push_t    push_i,
  output logic                room_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output b2w36_pkg::res_t     head_o
);

  b2w36_pkg::res_t                  mem_q [b2w36_pkg::QUEUE_DEPTH];
  logic [b2w36_pkg::PTR_W-1:0]      wr_q, rd_q;
  logic [b2w36_pkg::CNT_W-1:0]      cnt_q;
  logic                             pop;

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (cnt_q != '0);
  assign head_o      = mem_q[rd_q];
  // space for a full two-item push
  assign room_o      = (cnt_q <= b2w36_pkg::CNT_W'(b2w36_pkg::QUEUE_DEPTH - 2));

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem_q[wr_q] <= push_i.a;
    end
    if (push_i.cnt == 2'd2) begin
      mem_q[b2w36_pkg::PTR_W'(wr_q + 1'b1)] <= push_i.b;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= b2w36_pkg::PTR_W'(wr_q + b2w36_pkg::PTR_W'(push_i.cnt));
      rd_q  <= b2w36_pkg::PTR_W'(rd_q + b2w36_pkg::PTR_W'(pop));
      cnt_q <= b2w36_pkg::CNT_W'(cnt_q + b2w36_pkg::CNT_W'(push_i.cnt)
                                 - b2w36_pkg::CNT_W'(pop));
    end
  end

endmodule

// ----- design/byte_to_word36_packer.sv -----
// ----------------------------------------------------------------------------
// byte_to_word36_packer
// packs a byte stream into 36-bit words, with optional line feed expansion
// ----------------------------------------------------------------------------
// Input channel (in_valid_i/in_ready_o) carries one file byte per item and a
// last-byte mark. Output channel (out_valid_o/out_ready_i) carries packed
// words with final mark, sticky binary flag and saturating expanded length.
// cfg_we_i writes format_mode from cfg_wdata_i (0 text with line feed
// expansion, 1 seven-bit, 2 or 3 core-dump); write it while idle.
// A word is written to the result queue once its completing byte is accepted.
// Throughput: one byte per cycle while the queue has room; the packer and the
// four-entry result queue set that figure. A text-mode line feed may produce
// two words from one byte; the last byte flushes a padded partial word.
// in_ready_o drops only while the queue has fewer than two free entries, so
// a stalled receiver blocks input after the queue fills, without losing words.
// Reset: mode seven-bit, slot, word, binary flag and count cleared, queue empty.
// ----------------------------------------------------------------------------
module byte_to_word36_packer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [35:0] packed_word_o,
  output logic        final_word_o,
  output logic        binary_seen_o,
  output logic [31:0] expanded_length_o
);

  logic [1:0]        mode_q;
  logic              room;
  logic              accept;
  b2w36_pkg::push_t  push;
  b2w36_pkg::res_t   head;

  // mode register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= b2w36_pkg::MODE_SEVEN;
    end else if (cfg_we_i) begin
      mode_q <= cfg_wdata_i;
    end
  end

  assign in_ready_o = room;
  assign accept     = in_valid_i && room;

  // front: expansion and packing
  b2w36_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mode_i      (mode_q),
    .accept_i    (accept),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .push_o      (push)
  );

  // back: result queue feeding the output
  b2w36_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .head_o      (head)
  );

  assign packed_word_o     = head.word;
  assign final_word_o      = head.final_w;
  assign binary_seen_o     = head.binary;
  assign expanded_length_o = head.length;

endmodule

// ----- design/b2w36_checker.sv -----
// ----------------------------------------------------------------------------
// b2w36_checker
// port-level checks of the packer's output stream
// ----------------------------------------------------------------------------
`include "byte_to_word36_packer_defines.svh"

module b2w36_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [35:0] packed_word_i,
  input  logic        binary_seen_i,
  input  logic [31:0] expanded_length_i
);

  logic        seen_q;
  logic        have_q;
  logic [31:0] len_q;

  // history of delivered items
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= 1'b0;
      have_q <= 1'b0;
      len_q  <= '0;
    end else if (out_valid_i && out_ready_i) begin
      seen_q <= seen_q | binary_seen_i;
      have_q <= 1'b1;
      len_q  <= expanded_length_i;
    end
  end

  // stalled output item holds
  `B2W_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i,
                   out_valid_i && $stable(packed_word_i) && $stable(expanded_length_i),
                   "output item changed while stalled")

  // binary flag is sticky across items
  `B2W_ASSERT_IMPL(a_binary_sticky, clk_i, rst_ni, out_valid_i && seen_q,
                   binary_seen_i, "binary flag cleared after being reported")

  // expanded length never decreases
  `B2W_ASSERT_IMPL(a_length_mono, clk_i, rst_ni, out_valid_i && have_q,
                   expanded_length_i >= len_q, "expanded length went backwards")

endmodule

bind byte_to_word36_packer b2w36_checker u_b2w36_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .out_valid_i       (out_valid_o),
  .out_ready_i       (out_ready_i),
  .packed_word_i     (packed_word_o),
  .binary_seen_i     (binary_seen_o),
  .expanded_length_i (expanded_length_o)
);
